[design/mtt_pkg.sv]
// Shared types, codes and default parameter values of the multi-timer table.
package mtt_pkg;

  localparam int unsigned MAX_TIMERS_DEF  = 16;
  localparam int unsigned TICK_LENGTH_DEF = 100000;

  // Operation codes of an input item.
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_DEL  = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // Status codes of a result item.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] expire_time;
    logic        repeat_mode;
    logic [31:0] timer_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] result_id;
    logic        fired;
    logic        last;
  } out_item_t;

  // One row of the timer entry memory.
  typedef struct packed {
    logic [31:0] id;
    logic [31:0] count;
    logic [31:0] reload;
    logic        periodic;
  } ent_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       div_start;
    logic       add_commit;
    logic       reject;
    logic [1:0] rej_status;
    logic       ord_rd;
    logic       ent_rd;
    logic       proc;
    logic       finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       zero_ticks;
    logic       div_done;
    logic       ord_empty;
    logic       walk_last;
  } stat_t;

endpackage

[design/mtt_div.sv]
// Reciprocal-multiply unit that turns a time value into whole ticks in two steps.
module mtt_div #(
  parameter int unsigned TICK_LENGTH = mtt_pkg::TICK_LENGTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] dividend,
  output logic        done,
  output logic [31:0] quotient
);

  // The reciprocal is rounded up and scaled by 2^SH; with SH = 32 + ceil(log2 TICK_LENGTH)
  // the truncated product equals the quotient for every 32-bit dividend.
  localparam int unsigned SH      = 32 + $clog2(TICK_LENGTH);
  localparam logic [63:0] RECIP_W = ((64'd1 << SH) + 64'(TICK_LENGTH) - 64'd1) /
                                    64'(TICK_LENGTH);
  localparam logic [32:0] RECIP   = RECIP_W[32:0];

  logic        run_r;
  logic        hi_r;
  logic        done_r;
  logic [31:0] x_r;
  logic [64:0] acc_r;

  logic [15:0] half;
  logic [48:0] part;

  // The low half of the dividend is multiplied first, the high half second.
  assign half = hi_r ? x_r[31:16] : x_r[15:0];
  assign part = {33'd0, half} * {16'd0, RECIP};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      hi_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= run_r && hi_r;
      if (go) begin
        run_r <= 1'b1;
      end else if (run_r && hi_r) begin
        run_r <= 1'b0;
      end
      if (go) begin
        hi_r <= 1'b0;
      end else if (run_r) begin
        hi_r <= !hi_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      x_r <= dividend;
    end else if (run_r) begin
      acc_r <= hi_r ? (acc_r + {part, 16'd0}) : {16'd0, part};
    end
  end

  assign done     = done_r;
  assign quotient = 32'(acc_r >> SH);

endmodule

[design/mtt_ctrl.sv]
// Controller state machine that sequences add, delete and tick operations.
module mtt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  mtt_pkg::stat_t stat,
  output mtt_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DIVIDE,
    S_ADD_WR,
    S_ORD_RD,
    S_ENT_RD,
    S_PROC,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.op)
          mtt_pkg::OP_ADD: begin
            if (stat.full) begin
              cmd.reject     = 1'b1;
              cmd.rej_status = mtt_pkg::ST_FULL;
              state_nxt      = S_IDLE;
            end else if (stat.zero_ticks) begin
              cmd.reject     = 1'b1;
              cmd.rej_status = mtt_pkg::ST_ZERO;
              state_nxt      = S_IDLE;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIVIDE;
            end
          end
          mtt_pkg::OP_DEL, mtt_pkg::OP_TICK: begin
            state_nxt = stat.ord_empty ? S_FINISH : S_ORD_RD;
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_DIVIDE: begin
        if (stat.div_done) begin
          state_nxt = S_ADD_WR;
        end
      end
      S_ADD_WR: begin
        cmd.add_commit = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_ORD_RD: begin
        cmd.ord_rd = 1'b1;
        state_nxt  = S_ENT_RD;
      end
      S_ENT_RD: begin
        cmd.ent_rd = 1'b1;
        state_nxt  = S_PROC;
      end
      S_PROC: begin
        cmd.proc  = 1'b1;
        state_nxt = stat.walk_last ? S_FINISH : S_ORD_RD;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

[design/mtt_dp.sv]
// Datapath: timer entry memory, creation order list, tick divider and result register.
module mtt_dp #(
  parameter int unsigned MAX_TIMERS  = mtt_pkg::MAX_TIMERS_DEF,
  parameter int unsigned TICK_LENGTH = mtt_pkg::TICK_LENGTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mtt_pkg::in_item_t  in_data,
  input  mtt_pkg::cmd_t      cmd,
  output mtt_pkg::stat_t     stat,
  output logic               out_valid,
  output mtt_pkg::out_item_t out_data
);

  localparam int unsigned SW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int unsigned CW = $clog2(MAX_TIMERS + 1);

  mtt_pkg::in_item_t  item_r;
  logic [31:0]        next_id_r;
  logic [MAX_TIMERS-1:0] valid_r;
  logic [CW-1:0]      len_r;
  logic [CW-1:0]      idx_r;
  logic [CW-1:0]      kept_r;
  logic [SW-1:0]      free_slot_r;
  logic [SW-1:0]      free_slot_nxt;
  logic [SW-1:0]      ord_mem_r [MAX_TIMERS];
  logic [SW-1:0]      ord_q_r;
  mtt_pkg::ent_t      ent_mem_r [MAX_TIMERS];
  mtt_pkg::ent_t      ent_q_r;
  logic               pend_valid_r;
  logic [31:0]        pend_id_r;
  logic               out_valid_r;
  mtt_pkg::out_item_t out_r;

  logic               div_done;
  logic [31:0]        div_quot;
  logic [31:0]        id_nxt;
  logic               is_tick;
  logic               is_del;
  logic               is_walk;
  logic [31:0]        cnt_dec;
  logic               expire;
  logic               id_hit;
  logic               drop;
  mtt_pkg::ent_t      ent_upd;

  mtt_div #(
    .TICK_LENGTH(TICK_LENGTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.div_start),
    .dividend (item_r.expire_time),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign id_nxt  = next_id_r + 32'd1;
  assign is_tick = (item_r.operation == mtt_pkg::OP_TICK);
  assign is_del  = (item_r.operation == mtt_pkg::OP_DEL);
  assign is_walk = is_tick || is_del;

  // Per-entry work of a walk: a tick counts down, a delete compares the id.
  assign cnt_dec = ent_q_r.count - 32'd1;
  assign expire  = is_tick && (cnt_dec == 32'd0);
  assign id_hit  = is_del && valid_r[ord_q_r] && (ent_q_r.id == item_r.timer_id);
  assign drop    = id_hit || (expire && !ent_q_r.periodic);

  always_comb begin
    ent_upd       = ent_q_r;
    ent_upd.count = expire ? ent_q_r.reload : cnt_dec;
  end

  // Lowest free slot, registered; valid bits settle long before an add commits.
  always_comb begin
    free_slot_nxt = '0;
    for (int k = MAX_TIMERS - 1; k >= 0; k--) begin
      if (!valid_r[k]) begin
        free_slot_nxt = SW'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    free_slot_r <= free_slot_nxt;
    if (cmd.load) begin
      item_r <= in_data;
    end
  end

  // Creation order list, compacted in place while a walk proceeds.
  always_ff @(posedge clk) begin
    if (cmd.add_commit) begin
      ord_mem_r[len_r[SW-1:0]] <= free_slot_r;
    end else if (cmd.proc && !drop) begin
      ord_mem_r[kept_r[SW-1:0]] <= ord_q_r;
    end
    if (cmd.ord_rd) begin
      ord_q_r <= ord_mem_r[idx_r[SW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_commit) begin
      ent_mem_r[free_slot_r] <= '{id: id_nxt, count: div_quot, reload: div_quot,
                                  periodic: item_r.repeat_mode};
    end else if (cmd.proc && is_tick && !drop) begin
      ent_mem_r[ord_q_r] <= ent_upd;
    end
    if (cmd.ent_rd) begin
      ent_q_r <= ent_mem_r[ord_q_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_id_r    <= '0;
      valid_r      <= '0;
      len_r        <= '0;
      idx_r        <= '0;
      kept_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      // A new expiry releases the one held back, which is then known not to be final.
      out_valid_r <= cmd.add_commit || cmd.reject || cmd.finish ||
                     (cmd.proc && expire && pend_valid_r);
      if (cmd.load) begin
        idx_r        <= '0;
        kept_r       <= '0;
        pend_valid_r <= 1'b0;
      end
      if (cmd.add_commit) begin
        next_id_r              <= id_nxt;
        valid_r[free_slot_r]   <= 1'b1;
        len_r                  <= len_r + CW'(1);
      end
      if (cmd.proc) begin
        idx_r <= idx_r + CW'(1);
        if (drop) begin
          valid_r[ord_q_r] <= 1'b0;
        end else begin
          kept_r <= kept_r + CW'(1);
        end
        if (expire) begin
          pend_valid_r <= 1'b1;
        end
      end
      if (cmd.finish) begin
        pend_valid_r <= 1'b0;
        if (is_walk) begin
          len_r <= kept_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_commit) begin
      out_r <= '{status: mtt_pkg::ST_OK, result_id: id_nxt, fired: 1'b0, last: 1'b1};
    end else if (cmd.reject) begin
      out_r <= '{status: cmd.rej_status, result_id: 32'd0, fired: 1'b0, last: 1'b1};
    end else if (cmd.proc && expire) begin
      out_r     <= '{status: mtt_pkg::ST_OK, result_id: pend_id_r, fired: 1'b1,
                     last: 1'b0};
      pend_id_r <= ent_q_r.id;
    end else if (cmd.finish) begin
      if (pend_valid_r) begin
        out_r <= '{status: mtt_pkg::ST_OK, result_id: pend_id_r, fired: 1'b1,
                   last: 1'b1};
      end else begin
        out_r <= '{status: mtt_pkg::ST_OK, result_id: 32'd0, fired: 1'b0, last: 1'b1};
      end
    end
  end

  always_comb begin
    stat            = '0;
    stat.op         = item_r.operation;
    stat.full       = (len_r == CW'(MAX_TIMERS));
    stat.zero_ticks = (item_r.expire_time < 32'(TICK_LENGTH));
    stat.div_done   = div_done;
    stat.ord_empty  = (len_r == '0);
    stat.walk_last  = ((idx_r + CW'(1)) == len_r);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= CW'(MAX_TIMERS))
    else $error("order list longer than the table");

  // The length is only brought up to date at the end of a walk, so compare between items.
  a_len_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> $countones(valid_r) == int'(len_r))
    else $error("order list length differs from the number of live entries");

  a_add_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.add_commit |=> out_valid_r && out_r.status == mtt_pkg::ST_OK && out_r.last)
    else $error("committed add gave no ok result");

  a_finish_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r && out_r.last)
    else $error("finished walk gave no final result");

  a_nonlast_fired: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.last |-> out_r.fired)
    else $error("a non-final result is not an expiry");

endmodule

[design/multi_timer_table.sv]
// Top level of the multi-timer table: controller plus datapath.
//
// Input channel: in_data (operation, expire_time, repeat_mode, timer_id) transfers
// at a clock edge where start is high and busy is low. Results leave on out_data,
// each for exactly one cycle while out_valid is high; the receiver cannot stall.
// Add: the result follows the decode, the two-step reciprocal multiply that turns
// the time into ticks and the table write. A full table or a period under one
// tick is rejected and answered from the decode state.
// Delete and tick walk the creation order list; each live timer takes an order
// list read, an entry memory read and an update; a finish step closes the walk.
// A tick sends one fired result per expired timer in creation order, the last
// one flagged; with no expiry it sends one non-fired result. Delete and unused
// codes give one ok result.
// One item is worked at a time; busy stays high until the cycle in which its last
// result is on the ports.
// Reset empties the table and restarts ids at 1; the entry memories need no
// clearing because the order list length is reset.
module multi_timer_table #(
  parameter int unsigned MAX_TIMERS  = mtt_pkg::MAX_TIMERS_DEF,
  parameter int unsigned TICK_LENGTH = mtt_pkg::TICK_LENGTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mtt_pkg::in_item_t  in_data,
  output logic               out_valid,
  output mtt_pkg::out_item_t out_data
);

  mtt_pkg::cmd_t  cmd;
  mtt_pkg::stat_t stat;

  mtt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  mtt_dp #(
    .MAX_TIMERS  (MAX_TIMERS),
    .TICK_LENGTH (TICK_LENGTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[tb/multi_timer_table_check.sv]
// Checker that predicts the multi-timer table's results and compares them with the block.
module multi_timer_table_check
  import mtt_pkg::*;
#(
  parameter int unsigned MAX_TIMERS  = MAX_TIMERS_DEF,
  parameter int unsigned TICK_LENGTH = TICK_LENGTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  out_item_t   out_data,
  output int          fail_count,
  output int          outstanding,
  output logic [31:0] newest_id
);
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted timer table.
  logic        slot_used     [MAX_TIMERS];
  logic [31:0] slot_id       [MAX_TIMERS];
  logic [31:0] slot_count    [MAX_TIMERS];
  logic [31:0] slot_reload   [MAX_TIMERS];
  logic        slot_periodic [MAX_TIMERS];
  int unsigned order_list[$];
  logic [31:0] id_counter;

  out_item_t   expected_results[$];
  out_item_t   oldest_result;
  int          fail_total;

  assign fail_count = fail_total;

  initial begin
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    id_counter  = '0;
    fail_total  = 0;
    outstanding = 0;
    newest_id   = '0;
  end

  function automatic out_item_t make_result(input logic [1:0] st, input logic [31:0] id,
                                            input logic fire, input logic fin);
    out_item_t res;
    res.status    = st;
    res.result_id = id;
    res.fired     = fire;
    res.last      = fin;
    return res;
  endfunction

  task automatic predict_timer_results(input in_item_t item);
    logic [31:0] ticks;
    int          slot;
    int          fired_n;
    int unsigned kept[$];
    out_item_t   res;
    slot    = -1;
    fired_n = 0;
    case (item.operation)
      OP_ADD: begin
        ticks = item.expire_time / TICK_LENGTH;
        for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
          if (!slot_used[i]) slot = i;
        end
        if (order_list.size() >= MAX_TIMERS) begin
          expected_results.push_back(make_result(ST_FULL, '0, 1'b0, 1'b1));
        end else if (ticks == 0) begin
          expected_results.push_back(make_result(ST_ZERO, '0, 1'b0, 1'b1));
        end else if (slot < 0) begin
          expected_results.push_back(make_result(ST_FULL, '0, 1'b0, 1'b1));
        end else begin
          id_counter          = id_counter + 1;
          slot_used[slot]     = 1'b1;
          slot_id[slot]       = id_counter;
          slot_count[slot]    = ticks;
          slot_reload[slot]   = ticks;
          slot_periodic[slot] = item.repeat_mode;
          order_list.push_back(slot);
          expected_results.push_back(make_result(ST_OK, id_counter, 1'b0, 1'b1));
        end
      end
      OP_DEL: begin
        foreach (order_list[k]) begin
          slot = order_list[k];
          if (slot_id[slot] == item.timer_id) slot_used[slot] = 1'b0;
          else kept.push_back(slot);
        end
        order_list = kept;
        expected_results.push_back(make_result(ST_OK, '0, 1'b0, 1'b1));
      end
      OP_TICK: begin
        foreach (order_list[k]) begin
          slot = order_list[k];
          slot_count[slot] = slot_count[slot] - 1;
          if (slot_count[slot] == 0) begin
            expected_results.push_back(make_result(ST_OK, slot_id[slot], 1'b1, 1'b0));
            fired_n++;
            if (slot_periodic[slot]) begin
              slot_count[slot] = slot_reload[slot];
            end else begin
              // An expired one-shot timer leaves the creation order.
              slot_used[slot] = 1'b0;
              continue;
            end
          end
          kept.push_back(slot);
        end
        order_list = kept;
        if (fired_n == 0) begin
          expected_results.push_back(make_result(ST_OK, '0, 1'b0, 1'b1));
        end else begin
          res = expected_results.pop_back();
          res.last = 1'b1;
          expected_results.push_back(res);
        end
      end
      default: begin
        expected_results.push_back(make_result(ST_OK, '0, 1'b0, 1'b1));
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input out_item_t want,
                                 input out_item_t got);
    fail_total++;
    if (fail_total <= 10) begin
      $display("%0t mismatch (%s): expected status %0d id %0d fired %0b last %0b,",
               $realtime, what, want.status, want.result_id, want.fired, want.last);
      $display("    got status %0d id %0d fired %0b last %0b",
               got.status, got.result_id, got.fired, got.last);
    end
  endtask

  // Results are taken before new transfers so that a transfer on the edge of the
  // final result of the previous item is ordered correctly.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", '0, out_data);
        end else begin
          oldest_result = expected_results.pop_front();
          if (out_data.status !== oldest_result.status ||
              out_data.result_id !== oldest_result.result_id ||
              out_data.fired !== oldest_result.fired ||
              out_data.last !== oldest_result.last) begin
            report_mismatch("wrong field", oldest_result, out_data);
          end
        end
      end
      if (start && !busy) predict_timer_results(in_data);
      outstanding <= expected_results.size();
      newest_id   <= id_counter;
    end
  end

endmodule

[tb/multi_timer_table_test.sv]
// Top of the multi-timer table testbench: clock, reset, stimulus and verdict.
module multi_timer_table_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mtt_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  in_item_t    in_data = '0;
  logic        busy;
  logic        out_valid;
  out_item_t   out_data;
  int          fail_count;
  int          outstanding;
  logic [31:0] newest_id;
  int          idle_pct = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  multi_timer_table dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  multi_timer_table_check result_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .fail_count (fail_count),
    .outstanding(outstanding),
    .newest_id  (newest_id)
  );

  function automatic in_item_t build(input logic [1:0] op, input logic [31:0] t,
                                     input logic mode, input logic [31:0] id);
    in_item_t item;
    item.operation   = op;
    item.expire_time = t;
    item.repeat_mode = mode;
    item.timer_id    = id;
    return item;
  endfunction

  // Start may drop on any cycle, also while the block is busy, so that gaps land
  // on every phase of its work. The transfer happens on an edge with start high
  // and busy low.
  task automatic send_item(input in_item_t item);
    logic drove;
    logic done;
    done = 1'b0;
    in_data <= item;
    while (!done) begin
      drove = ($urandom_range(99) >= idle_pct);
      start <= drove;
      @(posedge clk);
      if (drove && !busy) done = 1'b1;
    end
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic random_phase(input int count);
    int          n;
    int          r;
    int          sel;
    in_item_t    item;
    n = 0;
    while (n < count) begin
      // Fields that the operation does not use carry random noise.
      item = build(OP_TICK, $urandom(), $urandom_range(1), $urandom());
      r = $urandom_range(99);
      if (r < 40) begin
        item.operation   = OP_ADD;
        item.repeat_mode = ($urandom_range(9) < 3);
        sel = $urandom_range(9);
        if (sel < 7) begin
          item.expire_time = $urandom_range(6, 1) * TICK_LENGTH_DEF +
                             $urandom_range(TICK_LENGTH_DEF - 1);
        end else if (sel < 8) begin
          item.expire_time = $urandom_range(TICK_LENGTH_DEF - 1);
        end else begin
          item.expire_time = $urandom();
        end
      end else if (r < 70) begin
        item.operation = OP_TICK;
      end else if (r < 95) begin
        item.operation = OP_DEL;
        // Mostly recent ids, so that deletes usually hit a live timer.
        if ($urandom_range(4) != 0 && newest_id != 0) begin
          if (newest_id > 8) item.timer_id = newest_id - $urandom_range(7);
          else item.timer_id = $urandom_range(newest_id, 1);
        end
      end else begin
        item.operation = OP_UNUSED;
      end
      send_item(item);
      if (item.operation != OP_UNUSED) n++;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_item(build(OP_TICK, '1, 1'b1, '1));
    send_item(build(OP_DEL, '0, 1'b0, '0));
    send_item(build(OP_UNUSED, '1, 1'b1, '1));
    send_item(build(OP_ADD, '0, 1'b1, '1));
    send_item(build(OP_ADD, TICK_LENGTH_DEF - 1, 1'b0, '0));
    send_item(build(OP_ADD, TICK_LENGTH_DEF, 1'b0, '0));
    send_item(build(OP_ADD, 2 * TICK_LENGTH_DEF, 1'b1, '0));
    send_item(build(OP_ADD, '1, 1'b1, '0));
    send_item(build(OP_TICK, '0, 1'b0, '0));
    send_item(build(OP_TICK, '0, 1'b0, '0));
    send_item(build(OP_DEL, '0, 1'b0, newest_id));
    wait_drained();

    // Fill the table, then overflow it, with a zero period also while full.
    repeat (15) send_item(build(OP_ADD, TICK_LENGTH_DEF + $urandom_range(TICK_LENGTH_DEF - 1),
                                1'b0, $urandom()));
    send_item(build(OP_ADD, TICK_LENGTH_DEF, 1'b0, '0));
    send_item(build(OP_ADD, '0, 1'b1, '0));
    send_item(build(OP_TICK, '0, 1'b0, '0));
    wait_drained();

    idle_pct = 20;
    random_phase(40);
    wait_drained();
    idle_pct = 88;
    random_phase(40);
    wait_drained();
    idle_pct = 0;
    random_phase(40);
    wait_drained();

    repeat (60) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[multi_timer_table] OK");
    end else begin
      $display("[multi_timer_table] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[multi_timer_table] ERROR");
    $finish;
  end

endmodule
